[rtl/pcms_pkg.sv]
// shared types and constants for the pixel crop, mirror and scale block
// no dependencies; used by every other file of the block
`default_nettype none

package pcms_pkg;

  localparam int PIX_W      = 8;
  localparam int DIM_W      = 11;
  localparam int OFF_W      = 10;
  localparam int SCALE_W    = 17;
  localparam int PROD_W     = 25;
  localparam int COORD_W    = 10;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 17;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IMAGE_HEIGHT     = 3'd0,
    REG_IMAGE_WIDTH      = 3'd1,
    REG_CROP_SIZE        = 3'd2,
    REG_MIRROR_ENABLE    = 3'd3,
    REG_SCALE_FACTOR     = 3'd4,
    REG_TRAIN_MODE       = 3'd5,
    REG_TRAIN_ROW_OFFSET = 3'd6,
    REG_TRAIN_COL_OFFSET = 3'd7
  } cfg_reg_t;

  // crop window geometry, all values bounded by the clamped dimensions
  typedef struct packed {
    logic [DIM_W-1:0] height;
    logic [DIM_W-1:0] width;
    logic [DIM_W-1:0] side_h;
    logic [DIM_W-1:0] side_w;
    logic [DIM_W-1:0] off_r;
    logic [DIM_W-1:0] off_c;
  } window_t;

  // a kept pixel between the crop stage and the scaling stage
  typedef struct packed {
    logic [PIX_W-1:0]   pixel;
    logic [SCALE_W-1:0] scale;
    logic [COORD_W-1:0] row;
    logic [COORD_W-1:0] col;
    logic               last;
  } crop_item_t;

endpackage

`default_nettype wire

[rtl/pcms_if.sv]
// valid/ready stream interfaces for pixels in and scaled pixels out
// depends on pcms_pkg
`default_nettype none

interface pcms_in_if;
  logic                      valid;
  logic                      ready;
  logic [pcms_pkg::PIX_W-1:0] pixel_value;

  modport source (output valid, output pixel_value, input ready);
  modport sink   (input valid, input pixel_value, output ready);
endinterface

interface pcms_out_if;
  logic                        valid;
  logic                        ready;
  logic [pcms_pkg::PROD_W-1:0]  scaled_value;
  logic [pcms_pkg::COORD_W-1:0] out_row;
  logic [pcms_pkg::COORD_W-1:0] out_col;
  logic                        plane_done;

  modport source (output valid, output scaled_value, output out_row, output out_col,
                  output plane_done, input ready);
  modport sink   (input valid, input scaled_value, input out_row, input out_col,
                  input plane_done, output ready);
endinterface

`default_nettype wire

[rtl/pcms_window.sv]
// crop window geometry from the configuration registers
// depends on pcms_pkg
`default_nettype none

module pcms_window #(
  parameter int MAX_DIM = 1024
) (
  input  wire logic [pcms_pkg::DIM_W-1:0] image_height,
  input  wire logic [pcms_pkg::DIM_W-1:0] image_width,
  input  wire logic [pcms_pkg::DIM_W-1:0] crop_size,
  input  wire logic                       train_mode,
  input  wire logic [pcms_pkg::OFF_W-1:0] train_row_offset,
  input  wire logic [pcms_pkg::OFF_W-1:0] train_col_offset,
  output pcms_pkg::window_t               geom
);

  logic [pcms_pkg::DIM_W-1:0] h;
  logic [pcms_pkg::DIM_W-1:0] w;
  logic [pcms_pkg::DIM_W-1:0] slack_h;
  logic [pcms_pkg::DIM_W-1:0] slack_w;
  logic [pcms_pkg::DIM_W-1:0] toff_r;
  logic [pcms_pkg::DIM_W-1:0] toff_c;

  // clamp a dimension to 1..MAX_DIM
  function automatic logic [pcms_pkg::DIM_W-1:0] clamp_dim(
    input logic [pcms_pkg::DIM_W-1:0] v
  );
    logic [pcms_pkg::DIM_W-1:0] res;
    res = v;
    if (v == '0) begin
      res = pcms_pkg::DIM_W'(1);
    end else if (32'(v) > 32'(MAX_DIM)) begin
      res = pcms_pkg::DIM_W'(MAX_DIM);
    end
    return res;
  endfunction

  always_comb begin
    h      = clamp_dim(image_height);
    w      = clamp_dim(image_width);
    toff_r = pcms_pkg::DIM_W'(train_row_offset);
    toff_c = pcms_pkg::DIM_W'(train_col_offset);

    geom        = '0;
    geom.height = h;
    geom.width  = w;

    if (crop_size == '0) begin
      geom.side_h = h;
      geom.side_w = w;
      slack_h     = '0;
      slack_w     = '0;
    end else begin
      geom.side_h = (crop_size < h) ? crop_size : h;
      geom.side_w = (crop_size < w) ? crop_size : w;
      slack_h     = h - geom.side_h;
      slack_w     = w - geom.side_w;
      if (train_mode) begin
        geom.off_r = (toff_r < slack_h) ? toff_r : slack_h;
        geom.off_c = (toff_c < slack_w) ? toff_c : slack_w;
      end else begin
        geom.off_r = slack_h >> 1;
        geom.off_c = slack_w >> 1;
      end
    end
  end

endmodule

`default_nettype wire

[rtl/pcms_crop.sv]
// raster counters, window test and output coordinates, one registered stage
// depends on pcms_pkg and pcms_if
`default_nettype none

module pcms_crop #(
  parameter int MAX_DIM = 1024
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  pcms_in_if.sink                           in_pix,
  input  wire pcms_pkg::window_t            geom,
  input  wire logic                         mirror_enable,
  input  wire logic [pcms_pkg::SCALE_W-1:0] scale_factor,
  input  wire logic                         take,
  output logic                              item_valid,
  output pcms_pkg::crop_item_t              item
);

  localparam int CW = $clog2(MAX_DIM);
  localparam int XW = ((CW > pcms_pkg::DIM_W) ? CW : pcms_pkg::DIM_W) + 1;

  logic [CW-1:0] row_count;
  logic [CW-1:0] col_count;
  logic [CW-1:0] row_count_next;
  logic [CW-1:0] col_count_next;

  logic [XW-1:0] r, c, h, w, off_r, off_c, side_h, side_w;
  logic [XW-1:0] orow, ocol, ocol_m;
  logic          keep, last, accept;
  pcms_pkg::crop_item_t item_next;

  assign in_pix.ready = !item_valid || take;
  assign accept       = in_pix.valid && in_pix.ready;

  always_comb begin
    r      = XW'(row_count);
    c      = XW'(col_count);
    h      = XW'(geom.height);
    w      = XW'(geom.width);
    off_r  = XW'(geom.off_r);
    off_c  = XW'(geom.off_c);
    side_h = XW'(geom.side_h);
    side_w = XW'(geom.side_w);

    keep = (r < h) && (c < w) && (r >= off_r) && (r < off_r + side_h) &&
           (c >= off_c) && (c < off_c + side_w);
    orow   = r - off_r;
    ocol   = c - off_c;
    last   = (orow == side_h - XW'(1)) && (ocol == side_w - XW'(1));
    ocol_m = mirror_enable ? (side_w - XW'(1) - ocol) : ocol;

    item_next.pixel = in_pix.pixel_value;
    item_next.scale = scale_factor;
    item_next.row   = orow[pcms_pkg::COORD_W-1:0];
    item_next.col   = ocol_m[pcms_pkg::COORD_W-1:0];
    item_next.last  = last;

    // wrap at row end and plane end; a counter left past a shrunk dimension drops to 0
    if (c + XW'(1) >= w) begin
      col_count_next = '0;
      row_count_next = (r + XW'(1) >= h) ? '0 : CW'(r + XW'(1));
    end else begin
      col_count_next = CW'(c + XW'(1));
      row_count_next = (r >= h) ? '0 : row_count;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_count  <= '0;
      col_count  <= '0;
      item_valid <= 1'b0;
    end else begin
      if (accept) begin
        row_count  <= row_count_next;
        col_count  <= col_count_next;
        item_valid <= keep;
      end else if (take) begin
        item_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item <= item_next;
    end
  end

endmodule

`default_nettype wire

[rtl/pcms_scale.sv]
// q1.16 scaling multiply into the output register
// depends on pcms_pkg and pcms_if
`default_nettype none

module pcms_scale (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 item_valid,
  input  wire pcms_pkg::crop_item_t item,
  output logic                      take,
  pcms_out_if.source                out_pix
);

  logic [pcms_pkg::PROD_W-1:0] product;

  assign take    = !out_pix.valid || out_pix.ready;
  // 8 x 17 bits gives the full 25 bit q9.16 product
  assign product = pcms_pkg::PROD_W'(item.pixel) * pcms_pkg::PROD_W'(item.scale);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_pix.valid <= 1'b0;
    end else if (take) begin
      out_pix.valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (take && item_valid) begin
      out_pix.scaled_value <= product;
      out_pix.out_row      <= item.row;
      out_pix.out_col      <= item.col;
      out_pix.plane_done   <= item.last;
    end
  end

endmodule

`default_nettype wire

[rtl/pixel_crop_mirror_scale.sv]
// pixel crop, mirror and scale: top level with configuration registers
// depends on pcms_pkg, pcms_if, pcms_window, pcms_crop and pcms_scale
`default_nettype none

// Takes one 8-bit pixel per clock while the output is not stalled, in raster
// order, plane after plane, and keeps only those inside a crop window of the crop
// size clamped to each dimension (centred, or at clamped offsets in train
// mode; crop size 0 keeps everything). Each kept pixel passes the window test
// register, then the output register, multiplied by the Q1.16 scale, with its
// row and column in the cropped plane (column reversed when mirroring) and
// plane_done on the last kept pixel. The two register stages (window test, then
// multiply) both advance every cycle the output is free. Configuration takes
// effect on the next input transfer and does not reset the raster counters.

module pixel_crop_mirror_scale #(
  parameter int MAX_DIM = 1024
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            cfg_wr_en,
  input  wire logic [pcms_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [pcms_pkg::CFG_DATA_W-1:0] cfg_data,
  pcms_in_if.sink                              in_pix,
  pcms_out_if.source                           out_pix
);

  logic [pcms_pkg::DIM_W-1:0]   image_height;
  logic [pcms_pkg::DIM_W-1:0]   image_width;
  logic [pcms_pkg::DIM_W-1:0]   crop_size;
  logic                         mirror_enable;
  logic [pcms_pkg::SCALE_W-1:0] scale_factor;
  logic                         train_mode;
  logic [pcms_pkg::OFF_W-1:0]   train_row_offset;
  logic [pcms_pkg::OFF_W-1:0]   train_col_offset;

  pcms_pkg::window_t    geom;
  pcms_pkg::crop_item_t item;
  logic                 item_valid;
  logic                 take;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_height     <= pcms_pkg::DIM_W'(1024);
      image_width      <= pcms_pkg::DIM_W'(1024);
      crop_size        <= '0;
      mirror_enable    <= 1'b0;
      scale_factor     <= pcms_pkg::SCALE_W'(65536);
      train_mode       <= 1'b0;
      train_row_offset <= '0;
      train_col_offset <= '0;
    end else if (cfg_wr_en) begin
      unique case (pcms_pkg::cfg_reg_t'(cfg_index))
        pcms_pkg::REG_IMAGE_HEIGHT:     image_height     <= cfg_data[pcms_pkg::DIM_W-1:0];
        pcms_pkg::REG_IMAGE_WIDTH:      image_width      <= cfg_data[pcms_pkg::DIM_W-1:0];
        pcms_pkg::REG_CROP_SIZE:        crop_size        <= cfg_data[pcms_pkg::DIM_W-1:0];
        pcms_pkg::REG_MIRROR_ENABLE:    mirror_enable    <= cfg_data[0];
        pcms_pkg::REG_SCALE_FACTOR:     scale_factor     <= cfg_data[pcms_pkg::SCALE_W-1:0];
        pcms_pkg::REG_TRAIN_MODE:       train_mode       <= cfg_data[0];
        pcms_pkg::REG_TRAIN_ROW_OFFSET: train_row_offset <= cfg_data[pcms_pkg::OFF_W-1:0];
        pcms_pkg::REG_TRAIN_COL_OFFSET: train_col_offset <= cfg_data[pcms_pkg::OFF_W-1:0];
        default: ;
      endcase
    end
  end

  pcms_window #(
    .MAX_DIM (MAX_DIM)
  ) u_window (
    .image_height     (image_height),
    .image_width      (image_width),
    .crop_size        (crop_size),
    .train_mode       (train_mode),
    .train_row_offset (train_row_offset),
    .train_col_offset (train_col_offset),
    .geom             (geom)
  );

  pcms_crop #(
    .MAX_DIM (MAX_DIM)
  ) u_crop (
    .clk           (clk),
    .rst           (rst),
    .in_pix        (in_pix),
    .geom          (geom),
    .mirror_enable (mirror_enable),
    .scale_factor  (scale_factor),
    .take          (take),
    .item_valid    (item_valid),
    .item          (item)
  );

  pcms_scale u_scale (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item       (item),
    .take       (take),
    .out_pix    (out_pix)
  );

endmodule

`default_nettype wire

[dv/pixel_crop_mirror_scale_tb.sv]
// testbench for pixel_crop_mirror_scale: pixel streams under many crop, mirror and
// scale settings, each kept pixel checked against a predictor held in a scoreboard
// depends on pcms_pkg, pcms_if and the pixel_crop_mirror_scale rtl
`timescale 1ns / 1ps

module pixel_crop_mirror_scale_tb;
  import pcms_pkg::*;

  localparam int MAX_DIM      = 1024;
  localparam int RANDOM_ITEMS = 1550;
  localparam int HOLD_CYCLES  = 300;
  localparam int PIPE_SLACK   = 4;
  localparam int DRAIN_LIMIT  = 5000;
  localparam int CYCLE_LIMIT  = 400000;

  typedef struct packed {
    logic [PROD_W-1:0]  scaled;
    logic [COORD_W-1:0] row;
    logic [COORD_W-1:0] col;
    logic               done;
  } pix_result_t;

  typedef enum logic [1:0] {RX_ALWAYS, RX_MOSTLY, RX_RARELY, RX_PATTERN} rx_mode_t;

  class crop_scoreboard;
    logic [DIM_W-1:0]   height, width, crop;
    logic               mirror, train;
    logic [SCALE_W-1:0] scale;
    logic [OFF_W-1:0]   train_row, train_col;
    logic [COORD_W-1:0] row_at, col_at;
    pix_result_t        expected_q[$];
    int                 errors;

    function new();
      height    = DIM_W'(MAX_DIM);
      width     = DIM_W'(MAX_DIM);
      crop      = '0;
      mirror    = 1'b0;
      scale     = SCALE_W'(65536);
      train     = 1'b0;
      train_row = '0;
      train_col = '0;
      row_at    = '0;
      col_at    = '0;
      errors    = 0;
    endfunction

    function void write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_IMAGE_HEIGHT:     height    = data[DIM_W-1:0];
        REG_IMAGE_WIDTH:      width     = data[DIM_W-1:0];
        REG_CROP_SIZE:        crop      = data[DIM_W-1:0];
        REG_MIRROR_ENABLE:    mirror    = data[0];
        REG_SCALE_FACTOR:     scale     = data[SCALE_W-1:0];
        REG_TRAIN_MODE:       train     = data[0];
        REG_TRAIN_ROW_OFFSET: train_row = data[OFF_W-1:0];
        REG_TRAIN_COL_OFFSET: train_col = data[OFF_W-1:0];
        default: ;
      endcase
    endfunction

    function int unsigned clamp_dim(logic [DIM_W-1:0] v);
      if (v == 0) return 1;
      if (v > MAX_DIM) return MAX_DIM;
      return v;
    endfunction

    // window side and start along one axis
    function void window_along(int unsigned dim, int unsigned toff,
                               output int unsigned side, output int unsigned off);
      if (crop == 0) begin
        side = dim;
        off  = 0;
      end else begin
        side = (crop < dim) ? crop : dim;
        if (train) off = (toff < dim - side) ? toff : dim - side;
        else off = (dim - side) / 2;
      end
    endfunction

    function void note_pixel(logic [PIX_W-1:0] pix);
      int unsigned h, w, r, c, side_h, side_w, off_r, off_c, orow, ocol, prod;
      pix_result_t res;
      h = clamp_dim(height);
      w = clamp_dim(width);
      window_along(h, train_row, side_h, off_r);
      window_along(w, train_col, side_w, off_c);
      r = row_at;
      c = col_at;
      if (r < h && c < w && r >= off_r && r < off_r + side_h &&
          c >= off_c && c < off_c + side_w) begin
        orow = r - off_r;
        ocol = c - off_c;
        res.done = (orow == side_h - 1) && (ocol == side_w - 1);
        if (mirror) ocol = side_w - 1 - ocol;
        prod = pix * scale;
        res.scaled = PROD_W'(prod);
        res.row    = COORD_W'(orow);
        res.col    = COORD_W'(ocol);
        expected_q.push_back(res);
      end
      // counters left past a shrunk dimension wrap on this step
      if (c + 1 >= w) begin
        col_at = '0;
        row_at = (r + 1 >= h) ? '0 : COORD_W'(r + 1);
      end else begin
        col_at = COORD_W'(c + 1);
        row_at = (r >= h) ? '0 : COORD_W'(r);
      end
    endfunction

    function void check_result(pix_result_t got);
      pix_result_t exp_res;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected pixel scaled_value %0d row %0d col %0d done %0d",
                 $time, got.scaled, got.row, got.col, got.done);
        errors++;
        return;
      end
      exp_res = expected_q.pop_front();
      if (got.scaled !== exp_res.scaled) begin
        $display("%0t: scaled_value expected %0d got %0d", $time, exp_res.scaled, got.scaled);
        errors++;
      end
      if (got.row !== exp_res.row) begin
        $display("%0t: out_row expected %0d got %0d", $time, exp_res.row, got.row);
        errors++;
      end
      if (got.col !== exp_res.col) begin
        $display("%0t: out_col expected %0d got %0d", $time, exp_res.col, got.col);
        errors++;
      end
      if (got.done !== exp_res.done) begin
        $display("%0t: plane_done expected %0d got %0d", $time, exp_res.done, got.done);
        errors++;
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function void flush();
      foreach (expected_q[i]) begin
        $display("%0t: missing pixel expected scaled_value %0d row %0d col %0d done %0d",
                 $time, expected_q[i].scaled, expected_q[i].row, expected_q[i].col,
                 expected_q[i].done);
        errors++;
      end
      expected_q.delete();
    endfunction
  endclass

  logic                  clk;
  logic                  rst = 1'b1;
  logic                  cfg_wr_en;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  bit                    hold_req = 1'b0;
  int                    pixels_sent = 0;
  int                    cycles = 0;
  crop_scoreboard        sb = new();

  pcms_in_if  in_pix();
  pcms_out_if out_pix();

  pixel_crop_mirror_scale #(.MAX_DIM(MAX_DIM)) dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_pix    (in_pix),
    .out_pix   (out_pix)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("[pixel_crop_mirror_scale] ERROR");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && in_pix.valid && in_pix.ready) sb.note_pixel(in_pix.pixel_value);
  end

  always @(posedge clk) begin
    pix_result_t got;
    if (!rst && out_pix.valid && out_pix.ready) begin
      got.scaled = out_pix.scaled_value;
      got.row    = out_pix.out_row;
      got.col    = out_pix.out_col;
      got.done   = out_pix.plane_done;
      sb.check_result(got);
    end
  end

  // output side stalls in segments of differing character, plus one long hold
  initial begin : receiver
    rx_mode_t    mode;
    int          seg_left;
    logic [7:0]  pattern;
    mode     = RX_ALWAYS;
    seg_left = 0;
    pattern  = '1;
    out_pix.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_pix.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        if (seg_left == 0) begin
          mode     = rx_mode_t'($urandom_range(0, 3));
          seg_left = $urandom_range(10, 200);
          pattern  = 8'($urandom);
        end
        seg_left--;
        case (mode)
          RX_ALWAYS: out_pix.ready <= 1'b1;
          RX_MOSTLY: out_pix.ready <= ($urandom_range(0, 3) != 0);
          RX_RARELY: out_pix.ready <= ($urandom_range(0, 3) == 0);
          default: begin
            out_pix.ready <= pattern[0];
            pattern = {pattern[0], pattern[7:1]};
          end
        endcase
      end
    end
  end

  function automatic logic [PIX_W-1:0] next_pixel();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      default: return PIX_W'($urandom);
    endcase
  endfunction

  function automatic int unsigned pick_dim();
    case ($urandom_range(0, 19))
      0: return 0;
      1: return 1;
      2: return MAX_DIM;
      3: return $urandom_range(MAX_DIM + 1, 2047);
      default: return $urandom_range(2, 12);
    endcase
  endfunction

  function automatic int unsigned pick_offset();
    case ($urandom_range(0, 5))
      0: return 0;
      1: return 1023;
      2: return $urandom_range(0, 1023);
      default: return $urandom_range(0, 12);
    endcase
  endfunction

  task automatic reg_write(cfg_reg_t idx, int unsigned value);
    logic [CFG_DATA_W-1:0] data;
    int                    fw;
    case (idx)
      REG_IMAGE_HEIGHT, REG_IMAGE_WIDTH, REG_CROP_SIZE: fw = DIM_W;
      REG_SCALE_FACTOR:                                 fw = SCALE_W;
      REG_TRAIN_ROW_OFFSET, REG_TRAIN_COL_OFFSET:       fw = OFF_W;
      default:                                          fw = 1;
    endcase
    data = CFG_DATA_W'(value);
    // junk above the register width must be ignored
    if (fw < CFG_DATA_W && $urandom_range(0, 1) == 1)
      data = data | (CFG_DATA_W'($urandom) << fw);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    sb.write_reg(idx, data);
    @(posedge clk);
  endtask

  task automatic configure(int unsigned h, int unsigned w, int unsigned crop,
                           int unsigned mirror, int unsigned scale, int unsigned train,
                           int unsigned trow, int unsigned tcol);
    reg_write(REG_IMAGE_HEIGHT, h);
    reg_write(REG_IMAGE_WIDTH, w);
    reg_write(REG_CROP_SIZE, crop);
    reg_write(REG_MIRROR_ENABLE, mirror);
    reg_write(REG_SCALE_FACTOR, scale);
    reg_write(REG_TRAIN_MODE, train);
    reg_write(REG_TRAIN_ROW_OFFSET, trow);
    reg_write(REG_TRAIN_COL_OFFSET, tcol);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic send_pixel(logic [PIX_W-1:0] pix);
    in_pix.valid       <= 1'b1;
    in_pix.pixel_value <= pix;
    do @(posedge clk); while (!in_pix.ready);
    pixels_sent++;
  endtask

  task automatic pause(int n);
    in_pix.valid       <= 1'b0;
    in_pix.pixel_value <= PIX_W'($urandom);
    repeat (n) @(posedge clk);
  endtask

  task automatic send_stream(int n, bit gappy);
    int burst;
    burst = $urandom_range(1, 24);
    for (int i = 0; i < n; i++) begin
      if (burst == 0) begin
        burst = $urandom_range(1, 24);
        if (gappy) pause($urandom_range(1, 6));
      end
      send_pixel(next_pixel());
      burst--;
    end
    in_pix.valid <= 1'b0;
  endtask

  // wait for every kept pixel to come out, then let dropped ones clear the pipe
  task automatic drain();
    int waited;
    waited = 0;
    @(posedge clk);
    while (sb.pending() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (PIPE_SLACK) @(posedge clk);
    sb.flush();
  endtask

  initial begin : stimulus
    int unsigned h, w, crop, scale, plane;
    int          n;
    in_pix.valid       = 1'b0;
    in_pix.pixel_value = '0;
    cfg_wr_en          = 1'b0;
    cfg_index          = REG_IMAGE_HEIGHT;
    cfg_data           = '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // register defaults: whole 1024 wide plane, unity scale
    send_pixel(8'h00);
    send_pixel(8'hFF);
    send_pixel(8'h55);
    send_pixel(8'hAA);
    in_pix.valid <= 1'b0;
    drain();

    // column counter left past the new width, centred 2x2 window, largest scale
    configure(4, 4, 2, 0, 131071, 0, 0, 0);
    send_stream(8, 1'b1);
    drain();

    // zero and oversize dimensions, crop larger than the image, mirror, zero scale
    configure(0, 2047, 2047, 1, 0, 1, 1023, 1023);
    send_stream(3, 1'b0);
    drain();

    // train row offset beyond the legal range, single pixel window
    configure(3, 5, 1, 1, 1, 1, 1023, 3);
    send_stream(10, 1'b1);
    drain();

    // receiver holds off while the sender keeps offering
    configure(16, 16, 0, $urandom_range(0, 1), $urandom_range(0, 131071), 0, 0, 0);
    hold_req = 1'b1;
    send_stream(64, 1'b0);
    drain();

    pixels_sent = 0;
    while (pixels_sent < RANDOM_ITEMS) begin
      h = pick_dim();
      w = pick_dim();
      case ($urandom_range(0, 9))
        0: crop = 0;
        1: crop = 1;
        2: crop = MAX_DIM;
        3: crop = $urandom_range(MAX_DIM + 1, 2047);
        default: crop = $urandom_range(1, 12);
      endcase
      case ($urandom_range(0, 5))
        0: scale = 0;
        1: scale = 131071;
        2: scale = 65536;
        default: scale = $urandom_range(0, 131071);
      endcase
      configure(h, w, crop, $urandom_range(0, 1), scale, $urandom_range(0, 1),
                pick_offset(), pick_offset());
      plane = sb.clamp_dim(DIM_W'(h)) * sb.clamp_dim(DIM_W'(w));
      // mostly whole planes; now and then a short broken run
      if ($urandom_range(0, 4) == 0) n = $urandom_range(1, 15);
      else if (plane <= 160) n = plane * $urandom_range(1, 3);
      else n = $urandom_range(20, 80);
      send_stream(n, $urandom_range(0, 3) != 0);
      drain();
    end

    if (sb.errors == 0) begin
      $display("[pixel_crop_mirror_scale] OK");
    end else begin
      $display("[pixel_crop_mirror_scale] ERROR");
    end
    $finish;
  end

endmodule
